@@ hw/rtl/trme_pkg.sv @@
// Shared types and constants of the register machine execute unit.
package trme_pkg;

	localparam int NUM_REGS_DEF = 6;
	localparam int PROG_DEPTH   = 1024;
	localparam int PC_W         = 10;
	localparam int REG_IDX_W    = 3;
	localparam int DATA_W       = 32;
	localparam int IMM_W        = 31;
	localparam int FUNC_W       = 3;
	localparam int DIV_CNT_W    = 5;

	typedef enum logic [FUNC_W-1:0] {
		OP_ADD   = 3'd0,
		OP_SUB   = 3'd1,
		OP_MUL   = 3'd2,
		OP_DIV   = 3'd3,
		OP_LET   = 3'd4,
		OP_PRINT = 3'd5,
		OP_BGE   = 3'd6,
		OP_BAD   = 3'd7
	} op_t;

	typedef struct packed {
		logic take_instr;
		logic rd_first;
		logic exec;
		logic div_step;
		logic wb;
	} trme_cmd_t;

	typedef struct packed {
		logic div_run;
		logic div_last;
		logic out_full;
	} trme_stat_t;

endpackage

@@ hw/rtl/trme_ctrl.sv @@
// Sequencer of the execute unit: register reads, execute, divide, writeback.
module trme_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  trme_pkg::trme_stat_t  stat,
	output trme_pkg::trme_cmd_t   cmd
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_RDA  = 6'b000010,
		ST_RDB  = 6'b000100,
		ST_EXEC = 6'b001000,
		ST_DIV  = 6'b010000,
		ST_WB   = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_RDA;
			end
			ST_RDA:  state_nxt = ST_RDB;
			ST_RDB:  state_nxt = ST_EXEC;
			ST_EXEC: state_nxt = stat.div_run ? ST_DIV : ST_WB;
			ST_DIV: begin
				if (stat.div_last) state_nxt = ST_WB;
			end
			ST_WB: begin
				if (!stat.out_full) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign in_ready       = (state_q == ST_IDLE);
	assign cmd.take_instr = in_valid && (state_q == ST_IDLE);
	assign cmd.rd_first   = (state_q == ST_RDA);
	assign cmd.exec       = (state_q == ST_EXEC);
	assign cmd.div_step   = (state_q == ST_DIV);
	assign cmd.wb         = (state_q == ST_WB) && !stat.out_full;

endmodule

@@ hw/rtl/trme_dp.sv @@
// Datapath: register file, ALU, bit-serial divider and result register.
module trme_dp #(
	parameter int NUM_REGS = trme_pkg::NUM_REGS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  trme_pkg::trme_cmd_t                cmd,
	output trme_pkg::trme_stat_t               stat,
	input  logic [trme_pkg::FUNC_W-1:0]        func,
	input  logic [trme_pkg::PC_W-1:0]          current_pc,
	input  logic [trme_pkg::REG_IDX_W-1:0]     dest_reg,
	input  logic [trme_pkg::REG_IDX_W-1:0]     src_a,
	input  logic [trme_pkg::REG_IDX_W-1:0]     src_b,
	input  logic [trme_pkg::IMM_W-1:0]         immediate,
	input  logic [trme_pkg::PC_W-1:0]          branch_target,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [trme_pkg::PC_W-1:0]          next_pc,
	output logic                               print_valid,
	output logic [trme_pkg::REG_IDX_W-1:0]     print_reg,
	output logic signed [trme_pkg::DATA_W-1:0] print_value,
	output logic                               div_zero,
	output logic                               bad_op
);

	localparam int RI_W = $clog2(NUM_REGS);
	localparam int PW   = trme_pkg::PC_W;
	localparam int DW   = trme_pkg::DATA_W;
	localparam int XW   = trme_pkg::REG_IDX_W;
	localparam logic [PW:0] DEPTH_C = (PW+1)'(trme_pkg::PROG_DEPTH);

	function automatic logic idx_ok(input logic [XW-1:0] i);
		return (32'(i) < NUM_REGS);
	endfunction

	function automatic logic [PW-1:0] pc_wrap(input logic [PW:0] v);
		logic [PW:0] r;
		r = (v >= DEPTH_C) ? (v - DEPTH_C) : v;
		return r[PW-1:0];
	endfunction

	// instruction
	trme_pkg::op_t       func_q;
	logic [PW-1:0]       pc_q;
	logic [PW-1:0]       tgt_q;
	logic [XW-1:0]       rd_q;
	logic [XW-1:0]       ra_q;
	logic [XW-1:0]       rb_q;
	logic [trme_pkg::IMM_W-1:0] imm_q;

	// register file
	logic [DW-1:0]       mem [NUM_REGS];
	logic [NUM_REGS-1:0] vld_q;
	logic [XW-1:0]       raddr;
	logic [RI_W-1:0]     ri;
	logic [RI_W-1:0]     wi;
	logic [DW-1:0]       rdata_q;
	logic [DW-1:0]       a_q;
	logic                wb_en;
	logic [DW-1:0]       wval;

	// execute results
	logic [DW-1:0]       res_q;
	logic                wr_q;
	logic [PW-1:0]       npc_q;
	logic                pv_q;
	logic [XW-1:0]       preg_q;
	logic [DW-1:0]       pval_q;
	logic                dz_q;
	logic                bad_q;

	// divider
	logic [DW-1:0]       quo_q;
	logic [DW-1:0]       rem_q;
	logic [DW-1:0]       dvs_q;
	logic                neg_q;
	logic [trme_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [DW:0]         shifted;
	logic                ge;
	logic [DW:0]         diff;

	// output beat
	logic                out_valid_q;
	logic [PW-1:0]       next_pc_q;
	logic                print_valid_q;
	logic [XW-1:0]       print_reg_q;
	logic [DW-1:0]       print_value_q;
	logic                div_zero_q;
	logic                bad_op_q;

	logic [DW-1:0]       b;
	logic [DW-1:0]       prod;
	logic [PW-1:0]       pc_inc;

	always_ff @(posedge clk) begin
		if (cmd.take_instr) begin
			func_q <= trme_pkg::op_t'(func);
			pc_q   <= current_pc;
			rd_q   <= dest_reg;
			ra_q   <= src_a;
			rb_q   <= src_b;
			imm_q  <= immediate;
			tgt_q  <= branch_target;
		end
	end

	assign raddr = cmd.rd_first ? ((func_q == trme_pkg::OP_PRINT) ? rd_q : ra_q) : rb_q;
	assign ri    = RI_W'(raddr);
	assign wi    = RI_W'(rd_q);

	always_ff @(posedge clk) begin
		rdata_q <= (idx_ok(raddr) && vld_q[ri]) ? mem[ri] : '0;
		a_q     <= rdata_q;
	end

	assign wval  = (func_q == trme_pkg::OP_DIV) ? (neg_q ? (DW'(0) - quo_q) : quo_q) : res_q;
	assign wb_en = cmd.wb && wr_q && idx_ok(rd_q);

	always_ff @(posedge clk) begin
		if (wb_en) begin
			mem[wi] <= wval;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wb_en) begin
			vld_q[wi] <= 1'b1;
		end
	end

	// b arrives in rdata_q during execute, a already moved to a_q
	assign b      = rdata_q;
	assign prod   = DW'(a_q * b);
	assign pc_inc = pc_wrap({1'b0, pc_q} + (PW+1)'(1));

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_q  <= '0;
			wr_q   <= 1'b0;
			npc_q  <= pc_inc;
			pv_q   <= 1'b0;
			preg_q <= '0;
			pval_q <= '0;
			dz_q   <= 1'b0;
			bad_q  <= 1'b0;
			quo_q  <= a_q[DW-1] ? (DW'(0) - a_q) : a_q;
			dvs_q  <= b[DW-1] ? (DW'(0) - b) : b;
			rem_q  <= '0;
			neg_q  <= a_q[DW-1] ^ b[DW-1];
			unique case (func_q)
				trme_pkg::OP_ADD: begin
					res_q <= a_q + b;
					wr_q  <= 1'b1;
				end
				trme_pkg::OP_SUB: begin
					res_q <= a_q - b;
					wr_q  <= 1'b1;
				end
				trme_pkg::OP_MUL: begin
					res_q <= prod;
					wr_q  <= 1'b1;
				end
				trme_pkg::OP_DIV: begin
					dz_q <= (b == '0);
					wr_q <= (b != '0);
				end
				trme_pkg::OP_LET: begin
					res_q <= {1'b0, imm_q};
					wr_q  <= 1'b1;
				end
				trme_pkg::OP_PRINT: begin
					pv_q   <= 1'b1;
					preg_q <= rd_q;
					pval_q <= a_q;
				end
				trme_pkg::OP_BGE: begin
					if ($signed(a_q) >= $signed(b)) npc_q <= pc_wrap({1'b0, tgt_q});
				end
				trme_pkg::OP_BAD: begin
					bad_q <= 1'b1;
					npc_q <= pc_wrap({1'b0, pc_q});
				end
				default: begin
					bad_q <= 1'b1;
				end
			endcase
		end else if (cmd.div_step) begin
			rem_q <= ge ? diff[DW-1:0] : shifted[DW-1:0];
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

	// restoring divide on magnitudes, one quotient bit per cycle
	assign shifted = {rem_q, quo_q[DW-1]};
	assign ge      = (shifted >= {1'b0, dvs_q});
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.exec) begin
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign stat.div_run  = (func_q == trme_pkg::OP_DIV) && (b != '0);
	assign stat.div_last = (cnt_q == '1);
	assign stat.out_full = out_valid_q && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.wb) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wb) begin
			next_pc_q     <= npc_q;
			print_valid_q <= pv_q;
			print_reg_q   <= preg_q;
			print_value_q <= pval_q;
			div_zero_q    <= dz_q;
			bad_op_q      <= bad_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign next_pc     = next_pc_q;
	assign print_valid = print_valid_q;
	assign print_reg   = print_reg_q;
	assign print_value = print_value_q;
	assign div_zero    = div_zero_q;
	assign bad_op      = bad_op_q;

endmodule

@@ hw/rtl/toy_register_machine_execute_top.sv @@
// Top level of the register machine execute unit.
// One instruction is worked on at a time. It passes through accept, two reads
// of the single-port register file, execute and writeback before its result
// beat; a divide with a nonzero divisor also passes through the divide state,
// where the restoring divider produces one quotient bit per cycle. The result
// sits in an output register, so the next instruction is accepted while a
// result beat still waits. Registers read as zero after reset.
module toy_register_machine_execute_top #(
	parameter int NUM_REGS = trme_pkg::NUM_REGS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [trme_pkg::FUNC_W-1:0]        func,
	input  logic [trme_pkg::PC_W-1:0]          current_pc,
	input  logic [trme_pkg::REG_IDX_W-1:0]     dest_reg,
	input  logic [trme_pkg::REG_IDX_W-1:0]     src_a,
	input  logic [trme_pkg::REG_IDX_W-1:0]     src_b,
	input  logic [trme_pkg::IMM_W-1:0]         immediate,
	input  logic [trme_pkg::PC_W-1:0]          branch_target,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [trme_pkg::PC_W-1:0]          next_pc,
	output logic                               print_valid,
	output logic [trme_pkg::REG_IDX_W-1:0]     print_reg,
	output logic signed [trme_pkg::DATA_W-1:0] print_value,
	output logic                               div_zero,
	output logic                               bad_op
);

	trme_pkg::trme_cmd_t  cmd;
	trme_pkg::trme_stat_t stat;

	trme_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	trme_dp #(
		.NUM_REGS (NUM_REGS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.func          (func),
		.current_pc    (current_pc),
		.dest_reg      (dest_reg),
		.src_a         (src_a),
		.src_b         (src_b),
		.immediate     (immediate),
		.branch_target (branch_target),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.next_pc       (next_pc),
		.print_valid   (print_valid),
		.print_reg     (print_reg),
		.print_value   (print_value),
		.div_zero      (div_zero),
		.bad_op        (bad_op)
	);

endmodule
